### rtl/gwps_pkg.sv
// Package with cell kinds, move codes and search directions of the wavefront router.
package gwps_pkg;

  localparam logic [1:0] KIND_FREE  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_GOAL  = 2'd2;
  localparam logic [1:0] KIND_WALL  = 2'd3;

  localparam logic [15:0] CODE_FREE  = 16'd0;
  localparam logic [15:0] CODE_START = 16'd1;
  localparam logic [15:0] CODE_GOAL  = 16'd2;
  localparam logic [15:0] CODE_WALL  = 16'd5;

  localparam logic [0:0] OP_LOAD  = 1'b0;
  localparam logic [0:0] OP_SOLVE = 1'b1;

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  localparam logic [2:0] MOVE_NONE  = 3'd0;
  localparam logic [2:0] MOVE_LEFT  = 3'd1;
  localparam logic [2:0] MOVE_RIGHT = 3'd2;
  localparam logic [2:0] MOVE_UP    = 3'd3;
  localparam logic [2:0] MOVE_DOWN  = 3'd4;

  localparam logic [1:0] DIR_YP = 2'd0;
  localparam logic [1:0] DIR_YM = 2'd1;
  localparam logic [1:0] DIR_XP = 2'd2;
  localparam logic [1:0] DIR_XM = 2'd3;

endpackage

### rtl/grid_wavefront_path_step.sv
// Grid cell store with a breadth-first wavefront router that reports the first move.
// A load transfer writes one cell. A solve transfer first sweeps the in-use area,
// one cell a cycle (clearing distance labels on the way), then runs
// the wavefront from a queue memory: each dequeued cell is read (S_DEQ, S_DEQW) and each
// neighbour read and checked (S_NRD, S_NCHK) through the single read port of the kind and
// label memories, then backtracks from the goal step by step (S_BRD, S_BCHK). One result
// transfer follows each solve; loads are taken while a result still waits, a new solve is not.
module grid_wavefront_path_step #(
  parameter int MAX_COLUMNS = 32,
  parameter int MAX_ROWS    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [0:0]  in_opcode,
  input  logic [4:0]  in_cell_x,
  input  logic [4:0]  in_cell_y,
  input  logic [15:0] in_cell_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_first_move,
  output logic        out_no_path,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [5:0]  cfg_wdata
);

  localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int WB    = $clog2(MAX_COLUMNS + 1);
  localparam int HB    = $clog2(MAX_ROWS + 1);
  localparam int AW    = CW + RW;
  localparam int DEPTH = 1 << AW;
  localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
  localparam int DW    = $clog2(CELLS + 2);
  localparam int QW    = AW + DW;
  localparam logic [WB-1:0] W_RST = WB'((MAX_COLUMNS < 32) ? MAX_COLUMNS : 32);
  localparam logic [HB-1:0] H_RST = HB'((MAX_ROWS < 32) ? MAX_ROWS : 32);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SDONE, S_SINIT, S_DEQ, S_DEQW, S_NRD, S_NCHK, S_BRD, S_BCHK
  } state_t;

  state_t        state_r;
  logic [WB-1:0] w_r;
  logic [HB-1:0] h_r;
  logic [CW-1:0] cur_x_r, n_x_r, sx_r, gx_r;
  logic [RW-1:0] cur_y_r, n_y_r, sy_r, gy_r;
  logic [CW-1:0] pend_x_r;
  logic [RW-1:0] pend_y_r;
  logic          pend_v_r;
  logic          have_start_r, goal_seen_r, found_r;
  logic [1:0]    k00_r;
  logic [1:0]    dir_r;
  logic [DW-1:0] cur_d_r, goal_d_r;
  logic [AW:0]   head_r, tail_r;
  logic          out_valid_r, out_no_path_r;
  logic [2:0]    out_first_move_r;

  logic [1:0]    kind_mem [DEPTH];
  logic [DW-1:0] dist_mem [DEPTH];
  logic [QW-1:0] q_mem [DEPTH];
  logic [1:0]    kind_q;
  logic [DW-1:0] dist_q;
  logic [QW-1:0] q_q;

  logic [AW-1:0] rd_addr, dist_waddr, load_addr;
  logic [DW-1:0] dist_wdata;
  logic          dist_we, q_we, kind_we;
  logic [1:0]    load_kind;
  logic [QW-1:0] q_wdata;
  logic [AW-1:0] start_addr, goal_addr, nb_addr;
  logic          nb_ok;
  logic [CW-1:0] nb_x;
  logic [RW-1:0] nb_y;
  logic          in_xfer, load_in;
  logic [9:0]    cfg_v;
  logic [DW-1:0] next_d;

  assign in_xfer    = in_valid && in_ready;
  assign in_ready   = (state_r == S_IDLE) && (!out_valid_r || (in_opcode == gwps_pkg::OP_LOAD));
  assign load_in    = (10'(in_cell_x) < 10'(MAX_COLUMNS)) && (10'(in_cell_y) < 10'(MAX_ROWS));
  assign load_addr  = {RW'(in_cell_y), CW'(in_cell_x)};
  assign kind_we    = in_xfer && (in_opcode == gwps_pkg::OP_LOAD) && load_in;
  assign start_addr = {sy_r, sx_r};
  assign goal_addr  = {gy_r, gx_r};
  assign nb_addr    = {nb_y, nb_x};
  assign next_d     = cur_d_r + DW'(1);
  assign cfg_v      = 10'(cfg_wdata);

  always_comb begin
    case (in_cell_code)
      gwps_pkg::CODE_FREE:  load_kind = gwps_pkg::KIND_FREE;
      gwps_pkg::CODE_START: load_kind = gwps_pkg::KIND_START;
      gwps_pkg::CODE_GOAL:  load_kind = gwps_pkg::KIND_GOAL;
      default:              load_kind = gwps_pkg::KIND_WALL;
    endcase
  end

  always_comb begin
    nb_x  = cur_x_r;
    nb_y  = cur_y_r;
    nb_ok = 1'b0;
    case (dir_r)
      gwps_pkg::DIR_YP: begin
        nb_ok = (HB'(cur_y_r) + HB'(1)) < h_r;
        nb_y  = cur_y_r + RW'(1);
      end
      gwps_pkg::DIR_YM: begin
        nb_ok = cur_y_r != '0;
        nb_y  = cur_y_r - RW'(1);
      end
      gwps_pkg::DIR_XP: begin
        nb_ok = (WB'(cur_x_r) + WB'(1)) < w_r;
        nb_x  = cur_x_r + CW'(1);
      end
      default: begin
        nb_ok = cur_x_r != '0;
        nb_x  = cur_x_r - CW'(1);
      end
    endcase
  end

  always_comb begin
    rd_addr    = nb_addr;
    dist_we    = 1'b0;
    dist_waddr = {cur_y_r, cur_x_r};
    dist_wdata = '0;
    q_we       = 1'b0;
    q_wdata    = {nb_addr, next_d};
    case (state_r)
      S_SCAN: begin
        rd_addr = {cur_y_r, cur_x_r};
        dist_we = 1'b1;
      end
      S_SINIT: begin
        dist_waddr = start_addr;
        dist_wdata = DW'(1);
        q_wdata    = {start_addr, DW'(1)};
        dist_we    = have_start_r && !(!goal_seen_r && (k00_r == gwps_pkg::KIND_WALL));
        q_we       = dist_we;
      end
      S_NCHK: begin
        dist_waddr = {n_y_r, n_x_r};
        dist_wdata = next_d;
        q_wdata    = {n_y_r, n_x_r, next_d};
        dist_we    = (kind_q != gwps_pkg::KIND_WALL) && (dist_q == '0);
        q_we       = dist_we;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (kind_we) begin
      kind_mem[load_addr] <= load_kind;
    end
    kind_q <= kind_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dist_waddr] <= dist_wdata;
    end
    dist_q <= dist_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[tail_r[AW-1:0]] <= q_wdata;
    end
    q_q <= q_mem[head_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= W_RST;
      h_r <= H_RST;
    end else if (cfg_we) begin
      if (cfg_index == gwps_pkg::REG_WIDTH) begin
        if (cfg_v == 10'd0) w_r <= WB'(1);
        else if (cfg_v > 10'(MAX_COLUMNS)) w_r <= WB'(MAX_COLUMNS);
        else w_r <= WB'(cfg_v);
      end else begin
        if (cfg_v == 10'd0) h_r <= HB'(1);
        else if (cfg_v > 10'(MAX_ROWS)) h_r <= HB'(MAX_ROWS);
        else h_r <= HB'(cfg_v);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      out_valid_r      <= 1'b0;
      out_no_path_r    <= 1'b0;
      out_first_move_r <= gwps_pkg::MOVE_NONE;
      pend_v_r         <= 1'b0;
      have_start_r     <= 1'b0;
      goal_seen_r      <= 1'b0;
      found_r          <= 1'b0;
      sx_r             <= '0;
      sy_r             <= '0;
      gx_r             <= '0;
      gy_r             <= '0;
      head_r           <= '0;
      tail_r           <= '0;
      dir_r            <= gwps_pkg::DIR_YP;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      pend_v_r <= (state_r == S_SCAN);
      if (pend_v_r) begin
        if (kind_q == gwps_pkg::KIND_START) begin
          sx_r         <= pend_x_r;
          sy_r         <= pend_y_r;
          have_start_r <= 1'b1;
        end
        if (kind_q == gwps_pkg::KIND_GOAL) begin
          gx_r        <= pend_x_r;
          gy_r        <= pend_y_r;
          goal_seen_r <= 1'b1;
        end
        if (pend_x_r == '0 && pend_y_r == '0) begin
          k00_r <= kind_q;
        end
      end
      if (q_we) begin
        tail_r <= tail_r + (AW + 1)'(1);
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer && (in_opcode == gwps_pkg::OP_SOLVE)) begin
            state_r      <= S_SCAN;
            cur_x_r      <= '0;
            cur_y_r      <= '0;
            have_start_r <= 1'b0;
            goal_seen_r  <= 1'b0;
            sx_r         <= '0;
            sy_r         <= '0;
            gx_r         <= '0;
            gy_r         <= '0;
            head_r       <= '0;
            tail_r       <= '0;
          end
        end
        S_SCAN: begin
          pend_x_r <= cur_x_r;
          pend_y_r <= cur_y_r;
          if ((WB'(cur_x_r) + WB'(1)) >= w_r) begin
            cur_x_r <= '0;
            if ((HB'(cur_y_r) + HB'(1)) >= h_r) begin
              state_r <= S_SDONE;
            end else begin
              cur_y_r <= cur_y_r + RW'(1);
            end
          end else begin
            cur_x_r <= cur_x_r + CW'(1);
          end
        end
        S_SDONE: begin
          state_r <= S_SINIT;
        end
        S_SINIT: begin
          head_r   <= '0;
          found_r  <= start_addr == goal_addr;
          goal_d_r <= DW'(1);
          if (q_we) begin
            state_r <= S_DEQ;
          end else begin
            state_r          <= S_IDLE;
            out_valid_r      <= 1'b1;
            out_no_path_r    <= 1'b1;
            out_first_move_r <= gwps_pkg::MOVE_NONE;
          end
        end
        S_DEQ: begin
          if (found_r) begin
            if (start_addr == goal_addr) begin
              state_r          <= S_IDLE;
              out_valid_r      <= 1'b1;
              out_no_path_r    <= 1'b0;
              out_first_move_r <= gwps_pkg::MOVE_NONE;
            end else begin
              cur_x_r <= gx_r;
              cur_y_r <= gy_r;
              cur_d_r <= goal_d_r;
              dir_r   <= gwps_pkg::DIR_YP;
              state_r <= S_BRD;
            end
          end else if (head_r == tail_r) begin
            state_r          <= S_IDLE;
            out_valid_r      <= 1'b1;
            out_no_path_r    <= 1'b1;
            out_first_move_r <= gwps_pkg::MOVE_NONE;
          end else begin
            head_r  <= head_r + (AW + 1)'(1);
            state_r <= S_DEQW;
          end
        end
        S_DEQW: begin
          {cur_y_r, cur_x_r, cur_d_r} <= q_q;
          dir_r   <= gwps_pkg::DIR_YP;
          state_r <= S_NRD;
        end
        S_NRD: begin
          if (nb_ok) begin
            n_x_r   <= nb_x;
            n_y_r   <= nb_y;
            state_r <= S_NCHK;
          end else if (dir_r == gwps_pkg::DIR_XM) begin
            state_r <= S_DEQ;
          end else begin
            dir_r <= dir_r + 2'd1;
          end
        end
        S_NCHK: begin
          if (dist_we && ({n_y_r, n_x_r} == goal_addr)) begin
            found_r  <= 1'b1;
            goal_d_r <= next_d;
            state_r  <= S_DEQ;
          end else if (dir_r == gwps_pkg::DIR_XM) begin
            state_r <= S_DEQ;
          end else begin
            dir_r   <= dir_r + 2'd1;
            state_r <= S_NRD;
          end
        end
        S_BRD: begin
          if (nb_ok) begin
            n_x_r   <= nb_x;
            n_y_r   <= nb_y;
            state_r <= S_BCHK;
          end else if (dir_r == gwps_pkg::DIR_XM) begin
            state_r          <= S_IDLE;
            out_valid_r      <= 1'b1;
            out_no_path_r    <= 1'b0;
            out_first_move_r <= gwps_pkg::MOVE_NONE;
          end else begin
            dir_r <= dir_r + 2'd1;
          end
        end
        S_BCHK: begin
          if ((dist_q != '0) && (dist_q < cur_d_r)) begin
            if ({n_y_r, n_x_r} == start_addr) begin
              state_r       <= S_IDLE;
              out_valid_r   <= 1'b1;
              out_no_path_r <= 1'b0;
              case (dir_r)
                gwps_pkg::DIR_YP: out_first_move_r <= gwps_pkg::MOVE_UP;
                gwps_pkg::DIR_YM: out_first_move_r <= gwps_pkg::MOVE_DOWN;
                gwps_pkg::DIR_XP: out_first_move_r <= gwps_pkg::MOVE_LEFT;
                default:          out_first_move_r <= gwps_pkg::MOVE_RIGHT;
              endcase
            end else begin
              cur_x_r <= n_x_r;
              cur_y_r <= n_y_r;
              cur_d_r <= dist_q;
              dir_r   <= gwps_pkg::DIR_YP;
              state_r <= S_BRD;
            end
          end else if (dir_r == gwps_pkg::DIR_XM) begin
            state_r          <= S_IDLE;
            out_valid_r      <= 1'b1;
            out_no_path_r    <= 1'b0;
            out_first_move_r <= gwps_pkg::MOVE_NONE;
          end else begin
            dir_r   <= dir_r + 2'd1;
            state_r <= S_BRD;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_first_move = out_first_move_r;
  assign out_no_path    = out_no_path_r;

endmodule
